[sv/bpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and command codes for the barometer compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned RawW = 19;

  localparam logic [CfgIdxW-1:0] REG_COEFF_A = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COEFF_B = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COEFF_C = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COEFF_D = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OSS = 3'd4;

  localparam logic [31:0] K_B6_OFS = 32'd4000;
  localparam logic [31:0] K_B4_OFS = 32'd32768;
  localparam logic [31:0] K_B7_SCALE = 32'd50000;
  localparam logic [31:0] K_MSB = 32'h8000_0000;
  localparam logic [31:0] K_P1 = 32'd3038;
  localparam logic [31:0] K_P2 = 32'd7357;
  localparam logic [31:0] K_P3 = 32'd3791;

  // Datapath operation codes; one per sequencer step.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_T_X1MUL,   // a = (ut - ac6) * ac5
    OP_T_DEN,     // x1 = a>>>15, den = x1 + md
    OP_T_DIVST,   // start signed divide num/den
    OP_T_FIN,     // b5 = x1 + q, result
    OP_P_B6,      // b6 = temp_term - 4000
    OP_P_SQ,      // sq = (b6*b6)>>>12
    OP_P_X1,      // acc = (b2*sq)>>>11
    OP_P_X2,      // acc += (ac2*b6)>>>11 ; b3
    OP_P_X3,      // t = (ac3*b6)>>>13
    OP_P_X4,      // t += (b1*sq)>>>16 ; x3
    OP_P_B4,      // b4 = (ac4*(x3+32768))>>15
    OP_P_B7,      // b7 = (up-b3)*(50000>>oss)
    OP_P_DIVST,   // start unsigned divide
    OP_P_PSQ,     // x1 = (p>>>8)^2
    OP_P_PK1,     // x1 = (x1*3038)>>>16
    OP_P_PK2,     // x2 = (-7357*p)>>>16
    OP_P_FIN      // result
  } op_t;

  typedef struct packed {
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic den_zero;
  } dp_sts_t;

  function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned s);
    sra32 = 32'($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

[sv/bpc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem[31:0], quotient[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
      end else begin
        rem <= {rem[30:0], quotient[31]};
      end
      quotient <= {quotient[30:0], ~trial[32]};
    end
  end
endmodule
`default_nettype wire

[sv/bpc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_datapath
// Registers, one shared 32x32 multiplier and the divider for compensation.
// ----------------------------------------------------------------------------
module bpc_datapath import bpc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                load,
  input  wire logic                pub,
  input  wire logic [RawW-1:0]     raw_in,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  output logic [31:0]              res_value
);
  logic [47:0] ca, cb;
  logic [31:0] cc, cd;
  logic [1:0]  oss;
  logic [31:0] temp_term;
  logic [31:0] raw;
  logic [31:0] a, b, c, d;
  logic [31:0] m_x, m_y, prod;
  logic        neg;
  logic        dstart;
  logic [31:0] dnd, dvs, q;
  logic        dbusy;
  logic [31:0] pval;
  logic [31:0] res_calc;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ca[47]}}, ca[47:32]};
  assign ac2 = {{16{ca[31]}}, ca[31:16]};
  assign ac3 = {{16{ca[15]}}, ca[15:0]};
  assign ac4 = {16'd0, cb[47:32]};
  assign ac5 = {16'd0, cb[31:16]};
  assign ac6 = {16'd0, cb[15:0]};
  assign b1  = {{16{cc[31]}}, cc[31:16]};
  assign b2  = {{16{cc[15]}}, cc[15:0]};
  assign mc  = {{16{cd[31]}}, cd[31:16]};
  assign md  = {{16{cd[15]}}, cd[15:0]};

  assign pval = neg ? (q << 1) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      ca <= '0;
      cb <= '0;
      cc <= '0;
      cd <= '0;
      oss <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEFF_A: ca <= cfg_data;
        REG_COEFF_B: cb <= cfg_data;
        REG_COEFF_C: cc <= cfg_data[31:0];
        REG_COEFF_D: cd <= cfg_data[31:0];
        REG_OSS:     oss <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // multiplier operands per step
  always_comb begin
    m_x = '0;
    m_y = '0;
    case (cmd.op)
      OP_T_X1MUL: begin m_x = raw - ac6; m_y = ac5; end
      OP_P_SQ:    begin m_x = b; m_y = b; end
      OP_P_X1:    begin m_x = b2; m_y = c; end
      OP_P_X2:    begin m_x = ac2; m_y = b; end
      OP_P_X3:    begin m_x = ac3; m_y = b; end
      OP_P_X4:    begin m_x = b1; m_y = c; end
      OP_P_B4:    begin m_x = ac4; m_y = a + K_B4_OFS; end
      OP_P_B7:    begin m_x = raw - d; m_y = K_B7_SCALE >> oss; end
      OP_P_PSQ:   begin m_x = sra32(pval, 8); m_y = sra32(pval, 8); end
      OP_P_PK1:   begin m_x = c; m_y = K_P1; end
      OP_P_PK2:   begin m_x = K_P2; m_y = a; end
      default: ;
    endcase
  end
  assign prod = m_x * m_y;

  logic [31:0] b3v;
  assign b3v = sra32(((ac1 << 2) + d + sra32(prod, 11)) << oss, 0) + 32'd2;

  assign dstart = (cmd.op == OP_T_DIVST && d != 32'd0) ||
                  (cmd.op == OP_P_DIVST && a != 32'd0);
  always_comb begin
    if (cmd.op == OP_T_DIVST) begin
      dnd = mc[31] ? 32'd0 - (mc << 11) : (mc << 11);
      dvs = d[31] ? 32'd0 - d : d;
    end else begin
      dnd = b[31] ? b : (b << 1);
      dvs = a;
    end
  end

  bpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dstart),
    .dividend (dnd),
    .divisor  (dvs),
    .busy     (dbusy),
    .quotient (q)
  );

  assign sts.div_busy = dbusy;
  assign sts.den_zero = (cmd.op == OP_T_DIVST) ? (d == 32'd0) : (a == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_term <= '0;
    end else if (cmd.op == OP_T_FIN) begin
      temp_term <= c + (neg ? 32'd0 - q : q);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      raw <= {13'd0, raw_in};
    end
    if (pub) begin
      res_value <= res_calc;
    end
    case (cmd.op)
      OP_T_X1MUL: a <= prod;
      OP_T_DEN: begin
        c <= sra32(a, 15);
        d <= sra32(a, 15) + md;
      end
      OP_T_DIVST: neg <= mc[31] ^ d[31];
      OP_T_FIN:   res_calc <= sra32(c + (neg ? 32'd0 - q : q) + 32'd8, 4);
      OP_P_B6:    b <= temp_term - K_B6_OFS;
      OP_P_SQ:    c <= sra32(prod, 12);
      OP_P_X1:    d <= sra32(prod, 11);
      OP_P_X2:    d <= sra32(b3v, 2);
      OP_P_X3:    a <= sra32(prod, 13);
      OP_P_X4:    a <= sra32(a + sra32(prod, 16) + 32'd2, 2);
      OP_P_B4:    a <= prod >> 15;
      OP_P_B7: begin
        b <= prod;
        neg <= prod[31];
      end
      OP_P_DIVST: ;
      OP_P_PSQ: begin
        a <= pval;
        c <= prod;
      end
      OP_P_PK1:   c <= sra32(prod, 16);
      OP_P_PK2:   d <= sra32(32'd0 - prod, 16);
      OP_P_FIN:   res_calc <= a + sra32(c + d + K_P3, 4);
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[sv/bpc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_ctrl
// Sequencer: walks the compensation steps and runs the output register.
// ----------------------------------------------------------------------------
module bpc_ctrl import bpc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic func,
  output logic      in_ready,
  output logic      load,
  output logic      pub,
  output dp_cmd_t   cmd,
  input  dp_sts_t   sts,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      kind,
  output logic      div_error
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RUN  = 6'b000010,
    S_WAIT = 6'b000100,
    S_DONE = 6'b001000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;
  logic   is_p;
  logic   err, err_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    err_next   = err;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RUN;
          op_next    = func ? OP_P_B6 : OP_T_X1MUL;
        end
      end
      S_RUN: begin
        if ((op == OP_T_DIVST || op == OP_P_DIVST) && sts.den_zero) begin
          state_next = S_DONE;
          err_next   = 1'b1;
        end else if (op == OP_T_DIVST || op == OP_P_DIVST) begin
          state_next = S_WAIT;
        end else if (op == OP_T_FIN || op == OP_P_FIN) begin
          state_next = S_DONE;
          err_next   = 1'b0;
        end else begin
          op_next = op_t'(op + 5'd1);
        end
      end
      S_WAIT: begin
        if (!sts.div_busy) begin
          state_next = S_RUN;
          op_next    = op_t'(op + 5'd1);
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign load     = in_ready && in_valid;
  assign pub      = (state == S_DONE) && (!out_valid || out_ready);
  assign cmd.op   = (state == S_RUN) ? op : OP_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_NONE;
      out_valid <= 1'b0;
      div_error <= 1'b0;
      err       <= 1'b0;
      kind      <= 1'b0;
      is_p      <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      err       <= err_next;
      if (load) begin
        is_p <= func;
      end
      if (pub) begin
        out_valid <= 1'b1;
        kind      <= is_p;
        div_error <= err;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[sv/barometer_pressure_temp_compensation.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barometer_pressure_temp_compensation
// Integer temperature and pressure compensation of raw barometer samples.
// ----------------------------------------------------------------------------
// Each sample runs from accept to out_valid through the sequencer steps, with a wait
// on the 32-step radix-2 divider. A zero divisor ends early.
// One item is in flight at a time; a new one is accepted only from the idle state.
// The output register lets the next item start while a result waits.
// Reset clears coefficients, oversampling and the stored B5 term to zero.
module barometer_pressure_temp_compensation import bpc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                func,
  input  wire logic [RawW-1:0]     raw_sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     kind,
  output logic signed [31:0]       value,
  output logic                     div_error
);
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        load;
  logic        pub;
  logic [31:0] res;

  bpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .func(func), .in_ready(in_ready),
    .load(load), .pub(pub), .cmd(cmd), .sts(sts), .out_valid(out_valid),
    .out_ready(out_ready), .kind(kind), .div_error(div_error)
  );

  bpc_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .load(load), .pub(pub), .raw_in(raw_sample), .cmd(cmd), .sts(sts),
    .res_value(res)
  );

  assign value = div_error ? 32'sd0 : $signed(res);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_error |-> value == 32'sd0) else $error("error value not zero");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.div_busy) else $error("accept while dividing");
endmodule
`default_nettype wire

[verif/tb_barometer_pressure_temp_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometer_pressure_temp_compensation
// Drives raw temperature and pressure samples through the compensation block
// under several coefficient sets, predicts each compensated reading in a
// scoreboard and compares kind, value and divide error field by field.
// ----------------------------------------------------------------------------
module tb_barometer_pressure_temp_compensation;
  import bpc_pkg::*;

  class comp_scoreboard;
    logic [47:0] coef_a, coef_b;
    logic [31:0] coef_c, coef_d;
    logic [1:0]  oss;
    logic [31:0] b5;
    logic [33:0] pending[$];
    int          errors;

    function new();
      coef_a = '0; coef_b = '0; coef_c = '0; coef_d = '0; oss = '0; b5 = '0;
      errors = 0;
    endfunction

    function logic [31:0] asr(logic [31:0] v, int s);
      return 32'($signed(v) >>> s);
    endfunction

    function logic [31:0] sx(logic [15:0] f);
      return {{16{f[15]}}, f};
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] d);
      case (idx)
        REG_COEFF_A: coef_a = d;
        REG_COEFF_B: coef_b = d;
        REG_COEFF_C: coef_c = d[31:0];
        REG_COEFF_D: coef_d = d[31:0];
        REG_OSS:     oss = d[1:0];
        default: ;
      endcase
    endfunction

    // note an accepted sample: compute {kind, div_error, value}
    function void note_sample(logic f, logic [18:0] raw);
      logic [31:0] x1, x2, x3, den, num, q, b6, sq, b3, b4, b7, p, ac5, ac6, up;
      logic [31:0] r;
      if (!f) begin
        ac5 = {16'h0, coef_b[31:16]};
        ac6 = {16'h0, coef_b[15:0]};
        x1 = asr((32'(raw) - ac6) * ac5, 15);
        den = x1 + sx(coef_d[15:0]);
        num = sx(coef_d[31:16]) << 11;
        if (den == 0) begin
          pending.push_back({1'b0, 1'b1, 32'h0});
        end else begin
          q = 32'($signed(num) / $signed(den));
          b5 = x1 + q;
          pending.push_back({1'b0, 1'b0, asr(b5 + 32'd8, 4)});
        end
      end else begin
        up = 32'(raw);
        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(sx(coef_c[15:0]) * sq, 11);
        x2 = asr(sx(coef_a[31:16]) * b6, 11);
        x3 = x1 + x2;
        b3 = asr(((sx(coef_a[47:32]) * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = asr(sx(coef_a[15:0]) * b6, 13);
        x2 = asr(sx(coef_c[31:16]) * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = ({16'h0, coef_b[47:32]} * (x3 + 32'd32768)) >> 15;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (b4 == 0) begin
          pending.push_back({1'b1, 1'b1, 32'h0});
        end else begin
          if (!b7[31]) p = (b7 << 1) / b4;
          else p = (b7 / b4) << 1;
          x1 = asr(p, 8) * asr(p, 8);
          x1 = asr(x1 * 32'd3038, 16);
          x2 = asr(32'd0 - 32'd7357 * p, 16);
          r = p + asr(x1 + x2 + 32'd3791, 4);
          pending.push_back({1'b1, 1'b0, r});
        end
      end
    endfunction

    function void check_result(logic k, logic [31:0] v, logic de);
      logic [33:0] e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d value=%0d", k, $signed(v));
        errors++;
        return;
      end
      e = pending.pop_front();
      if (k !== e[33]) begin
        $error("kind: expected %0d actual %0d", e[33], k); errors++;
      end
      if (de !== e[32]) begin
        $error("div_error: expected %0d actual %0d", e[32], de); errors++;
      end
      if (v !== e[31:0]) begin
        $error("value: expected %0d actual %0d", $signed(e[31:0]), $signed(v));
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [18:0] raw_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic signed [31:0] value;
  logic        div_error;

  comp_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;

  always #1 clk = ~clk;

  barometer_pressure_temp_compensation dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .raw_sample(raw_sample),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .value(value),
    .div_error(div_error)
  );

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(kind, value, div_error);
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= quiet_phase || ($urandom_range(99) >= 14);
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] d);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
    sb.set_reg(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(logic f, logic [18:0] raw);
    while (!quiet_phase && $urandom_range(99) < 14) @(posedge clk);
    in_valid <= 1'b1; func <= f; raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(f, raw);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // calibration close to a real part, so most pressures land near sea level
  task automatic load_typical(logic [1:0] o);
    write_reg(REG_COEFF_A, {16'd408, -16'sd72, -16'sd14383});
    write_reg(REG_COEFF_B, {16'd32741, 16'd32757, 16'd23153});
    write_reg(REG_COEFF_C, {16'd0, 16'd6190, 16'd4});
    write_reg(REG_COEFF_D, {16'd0, -16'sd8711, 16'd2868});
    write_reg(REG_OSS, {46'h0, o});
  endtask

  task automatic random_regs();
    write_reg(REG_COEFF_A, 48'({$urandom, $urandom}));
    write_reg(REG_COEFF_B, 48'({$urandom, $urandom}));
    write_reg(REG_COEFF_C, {16'h0, $urandom});
    write_reg(REG_COEFF_D, {16'h0, $urandom});
    write_reg(REG_OSS, 48'($urandom_range(3)));
  endtask

  task automatic random_run(int n, bit typical);
    logic [18:0] r;
    for (int i = 0; i < n; i++) begin
      if (typical && $urandom_range(9) != 0)
        r = ($urandom_range(1) == 0) ? 19'($urandom_range(20000, 35000))
                                     : 19'($urandom_range(20000, 450000));
      else r = 19'($urandom);
      send_sample(($urandom_range(2) != 0), r);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // pressure before any temperature, all-zero coefficients: zero divisors
    send_sample(1'b1, 19'd0);
    send_sample(1'b0, 19'd0);
    send_sample(1'b1, 19'h7FFFF);
    drain();
    load_typical(2'd0);
    send_sample(1'b0, 19'd27898);
    send_sample(1'b1, 19'd23843);
    send_sample(1'b0, 19'h7FFFF);
    send_sample(1'b1, 19'h7FFFF);
    send_sample(1'b0, 19'd0);
    send_sample(1'b1, 19'd0);
    drain();
    // temperature with zero divisor keeps the stored term
    write_reg(REG_COEFF_B, {16'd32741, 16'd0, 16'd0});
    write_reg(REG_COEFF_D, {16'd0, 16'd5, 16'd0});
    send_sample(1'b0, 19'd1234);
    send_sample(1'b1, 19'd40000);
    drain();
    write_reg(REG_COEFF_A, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_COEFF_B, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_COEFF_C, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_COEFF_D, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_OSS, 48'hFFFF_FFFF_FFFF);
    write_reg(3'd7, 48'h1234_5678_9ABC);
    send_sample(1'b0, 19'h7FFFF);
    send_sample(1'b1, 19'h7FFFF);
    send_sample(1'b0, 19'h55555);
    send_sample(1'b1, 19'h2AAAA);
    drain();
    for (int o = 0; o < 4; o++) begin
      load_typical(2'(o));
      random_run(150, 1'b1);
      drain();
    end
    quiet_phase = 1'b1;
    random_run(120, 1'b1);
    drain();
    quiet_phase = 1'b0;
    for (int k = 0; k < 3; k++) begin
      random_regs();
      random_run(80, 1'b0);
      drain();
    end
    // block fills up while the receiver holds off
    load_typical(2'd3);
    hold_off = 1'b1;
    fork
      random_run(10, 1'b1);
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    random_run(70, 1'b1);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_barometer_pressure_temp_compensation OK");
    else
      $display("tb_barometer_pressure_temp_compensation NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_barometer_pressure_temp_compensation NOT OK");
    $finish;
  end
endmodule
